FILE: rtl/core/psrp_pkg.sv
package psrp_pkg;

   localparam logic [7:0] CharCr   = 8'h0D;
   localparam logic [7:0] CharO    = 8'h4F;
   localparam logic [7:0] CharK    = 8'h4B;
   localparam logic [7:0] CharOne  = 8'h31;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;

   localparam int unsigned ValueWidth = 14;
   localparam int unsigned PosWidth   = 4;

   // line positions: voltage digits below VoltEnd, current digits below AmpEnd
   localparam logic [PosWidth-1:0] VoltEnd  = 4'd4;
   localparam logic [PosWidth-1:0] AmpEnd   = 4'd8;
   localparam logic [PosWidth-1:0] ModePos  = 4'd8;
   localparam logic [PosWidth-1:0] PosLimit = 4'd9;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [ValueWidth-1:0] voltage_centivolts;
      logic [ValueWidth-1:0] current_centiamps;
      logic                  constant_current;
      logic                  output_on;
   } rsp_payload_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CharZero) && (b <= CharNine);
   endfunction

   // acc * 10 + digit, wrapped to the field width
   function automatic logic [ValueWidth-1:0] next_accum(input logic [ValueWidth-1:0] acc,
                                                        input logic [7:0] b);
      logic [ValueWidth+3:0] wide;
      logic [7:0]            digit;
      digit = b - CharZero;
      wide  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(ValueWidth-4){1'b0}}, digit};
      return wide[ValueWidth-1:0];
   endfunction

endpackage

FILE: rtl/core/psrp_stream_if.sv
interface psrp_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/psu_status_reply_parser_unit.sv
// Each accepted byte is registered in byte_ff and decoded from there; a result
//   produced by a closing "OK\r" is registered in out_ff as its last byte is decoded.
// Throughput: one byte per cycle, set by the single input register and result register;
//   req_ stalls only while a result is held in the result register and a new one is due.
// Reset (synchronous, active high) clears the parse state, the tail match and both valids.
module psu_status_reply_parser_unit
   import psrp_pkg::*;
(
   input logic           clock,
   input logic           reset,
   psrp_stream_if.sink   req_chan,
   psrp_stream_if.source rsp_chan
);

   logic                  in_valid_ff;
   logic [7:0]            byte_ff;
   logic                  out_valid_ff;
   rsp_payload_type       out_ff;

   logic [15:0]           tail_ff, tail_in;
   logic [PosWidth-1:0]   line_pos_ff, line_pos_in;
   logic                  line_over_ff, line_over_in;
   logic [ValueWidth-1:0] volt_ff, volt_in;
   logic [ValueWidth-1:0] amp_ff, amp_in;
   logic [1:0]            stopped_ff, stopped_in;
   logic                  mode_ff, mode_in;

   logic                  match;
   logic                  advance;

   // hold the decode stage only when it would overwrite a waiting result
   assign advance        = in_valid_ff && (!match || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      tail_in      = tail_ff;
      line_pos_in  = line_pos_ff;
      line_over_in = line_over_ff;
      volt_in      = volt_ff;
      amp_in       = amp_ff;
      stopped_in   = stopped_ff;
      mode_in      = mode_ff;
      match        = 1'b0;
      if (in_valid_ff) begin
         if (!line_over_ff) begin
            if (byte_ff == CharCr) begin
               line_over_in = 1'b1;
            end else begin
               if (line_pos_ff < VoltEnd) begin
                  if (!stopped_ff[0]) begin
                     if (is_digit(byte_ff)) volt_in = next_accum(volt_ff, byte_ff);
                     else stopped_in[0] = 1'b1;
                  end
               end else if (line_pos_ff < AmpEnd) begin
                  if (!stopped_ff[1]) begin
                     if (is_digit(byte_ff)) amp_in = next_accum(amp_ff, byte_ff);
                     else stopped_in[1] = 1'b1;
                  end
               end else if (line_pos_ff == ModePos) begin
                  mode_in = (byte_ff == CharOne);
               end
               if (line_pos_ff < PosLimit) line_pos_in = line_pos_ff + PosWidth'(1);
            end
         end
         match   = (byte_ff == CharCr) && (tail_ff == {CharO, CharK});
         tail_in = {tail_ff[7:0], byte_ff};
         // drop all state once a reply is closed
         if (match) begin
            tail_in      = '0;
            line_pos_in  = '0;
            line_over_in = 1'b0;
            volt_in      = '0;
            amp_in       = '0;
            stopped_in   = '0;
            mode_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         byte_ff <= req_chan.payload.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff      <= '0;
         line_pos_ff  <= '0;
         line_over_ff <= 1'b0;
         volt_ff      <= '0;
         amp_ff       <= '0;
         stopped_ff   <= '0;
         mode_ff      <= 1'b0;
      end else if (advance) begin
         tail_ff      <= tail_in;
         line_pos_ff  <= line_pos_in;
         line_over_ff <= line_over_in;
         volt_ff      <= volt_in;
         amp_ff       <= amp_in;
         stopped_ff   <= stopped_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && match) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && match) begin
         out_ff.voltage_centivolts <= volt_ff;
         out_ff.current_centiamps  <= amp_ff;
         out_ff.constant_current   <= mode_ff;
         out_ff.output_on          <= (volt_ff != '0);
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      advance && match |=> (line_pos_ff == '0) && (volt_ff == '0) && (amp_ff == '0)
                           && (tail_ff == '0) && !line_over_ff)
      else $error("parse state not cleared after a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      advance && match |-> !out_valid_ff || rsp_chan.ready)
      else $error("pending result overwritten");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      line_pos_ff <= PosLimit)
      else $error("line position past its limit");

   a_output_on: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.output_on == (out_ff.voltage_centivolts != '0))
      else $error("output_on disagrees with voltage");

   a_stall_only_on_result: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> match && out_valid_ff)
      else $error("decode stage stalled without a pending result");

endmodule
